// ===== hdl/scss_pkg.sv =====
// ----------------------------------------------------------------------------
// scss_pkg: shared types and constants of the size class segment selector
// Segment counts per class, alignment, field widths, codes and the
// write request that goes into the free count bank.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package scss_pkg;

  // Segments per size class; segments are numbered small, medium, large.
  localparam int SMALL_SEGS  = 4;
  localparam int MEDIUM_SEGS = 4;
  localparam int LARGE_SEGS  = 4;
  // Must be a power of two.
  localparam int ALIGN_BYTES = 8;

  localparam int TOTAL_SEGS = SMALL_SEGS + MEDIUM_SEGS + LARGE_SEGS;
  localparam int MAX_CLASS_SEGS =
      (SMALL_SEGS > MEDIUM_SEGS) ?
        ((SMALL_SEGS > LARGE_SEGS) ? SMALL_SEGS : LARGE_SEGS) :
        ((MEDIUM_SEGS > LARGE_SEGS) ? MEDIUM_SEGS : LARGE_SEGS);

  localparam int SEG_W = $clog2(TOTAL_SEGS);
  localparam int LOC_W = (MAX_CLASS_SEGS > 1) ? $clog2(MAX_CLASS_SEGS) : 1;
  localparam int CNT_W = $clog2(MAX_CLASS_SEGS + 1);

  // Field widths
  localparam int SEG_ID_W  = 4;
  localparam int BYTES_W   = 32;
  localparam int BUSY_W    = 12;
  localparam int ALIGNED_W = 33;
  localparam int NEED_W    = 34;
  localparam int HDR_W     = 8;
  localparam int CLS_W     = 2;

  // tdata layouts
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 40;

  localparam int CFG_IDX_W = 2;

  localparam logic [ALIGNED_W-1:0] ALIGN_MASK = ALIGNED_W'(ALIGN_BYTES - 1);

  localparam logic [CLS_W-1:0] CLS_SMALL  = 2'd0;
  localparam logic [CLS_W-1:0] CLS_MEDIUM = 2'd1;
  localparam logic [CLS_W-1:0] CLS_LARGE  = 2'd2;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SELECT = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SMALL_LIMIT  = 2'd0,
    REG_MEDIUM_LIMIT = 2'd1,
    REG_HEADER_BYTES = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ALIGN,
    S_CLASS,
    S_SCAN
  } scss_state_t;

  typedef struct packed {
    logic               en;
    logic [SEG_W-1:0]   idx;
    logic [BYTES_W-1:0] data;
  } fc_wr_t;

  function automatic logic [SEG_W-1:0] class_base(input logic [CLS_W-1:0] cls);
    logic [SEG_W-1:0] b;
    case (cls)
      CLS_SMALL:  b = '0;
      CLS_MEDIUM: b = SEG_W'(SMALL_SEGS);
      default:    b = SEG_W'(SMALL_SEGS + MEDIUM_SEGS);
    endcase
    return b;
  endfunction

  function automatic logic [CNT_W-1:0] class_count(input logic [CLS_W-1:0] cls);
    logic [CNT_W-1:0] n;
    case (cls)
      CLS_SMALL:  n = CNT_W'(SMALL_SEGS);
      CLS_MEDIUM: n = CNT_W'(MEDIUM_SEGS);
      default:    n = CNT_W'(LARGE_SEGS);
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/size_class_segment_selector.sv =====
// ----------------------------------------------------------------------------
// size_class_segment_selector: next-fit segment choice by size class
// Keeps per-segment free byte counts and picks a segment for a request.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one item per handshake; in_tuser is the opcode (load or select).
//           A load writes one segment's free count, a select asks for a
//           segment that fits the aligned request plus the header.
//   out_* : one result item per input item, held until out_tready.
//   cfg_* : register writes (small_limit, medium_limit, header_bytes), taken
//           at any time, always ready; write only while the block is idle.
// Timing: a load shows its result in the cycle after acceptance. A select
//   goes through the align and class states and then scans k segments
//   (1 up to the class size, 0 for a zero request); the single fit
//   comparator checks one segment per cycle.
// Throughput: one item at a time; in_tready is high only when no item is in
//   work and the output register is empty, so a stalled receiver holds off
//   the next item.
// Reset: free counts and last used segments go to zero, the registers to
//   their defaults (256, 4096, 16); no item and no result is pending.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module size_class_segment_selector (
  input  wire                                 clk,
  input  wire                                 rst_n,
  // segment_id[3:0], free_amount[35:4], request_bytes[67:36], busy_mask[79:68]
  input  wire [scss_pkg::IN_DATA_W-1:0]       in_tdata,
  // opcode[0]
  input  wire                                 in_tuser,
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  // found[0], chosen_segment[4:1], size_class[6:5], aligned_bytes[39:7]
  output logic [scss_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire [scss_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire [scss_pkg::BYTES_W-1:0]         cfg_data
);
  import scss_pkg::*;

  scss_state_t state_r, state_nxt;

  logic [BYTES_W-1:0]   req_r, req_nxt;
  logic [BUSY_W-1:0]    busy_r, busy_nxt;
  logic [ALIGNED_W-1:0] aligned_r, aligned_nxt;
  logic [NEED_W-1:0]    need_r, need_nxt;
  logic [CLS_W-1:0]     cls_r, cls_nxt;
  logic [SEG_W-1:0]     base_r, base_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [LOC_W-1:0]     loc_r, loc_nxt;
  logic [CNT_W-1:0]     scan_cnt_r, scan_cnt_nxt;
  logic                 have_fb_r, have_fb_nxt;
  logic [SEG_W-1:0]     fb_idx_r, fb_idx_nxt;
  logic [BYTES_W-1:0]   fb_free_r, fb_free_nxt;
  logic [SEG_W-1:0]     last_used_r [3];
  logic [SEG_W-1:0]     last_used_nxt [3];

  logic [BYTES_W-1:0]   small_limit_r, medium_limit_r;
  logic [HDR_W-1:0]     header_r;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_found_r, out_found_nxt;
  logic [SEG_ID_W-1:0]  out_seg_r, out_seg_nxt;
  logic [CLS_W-1:0]     out_cls_r, out_cls_nxt;
  logic [ALIGNED_W-1:0] out_aligned_r, out_aligned_nxt;

  fc_wr_t               fc_wr;
  logic [SEG_W-1:0]     cur_idx;
  logic [BYTES_W-1:0]   cur_free;
  logic                 cur_fits;
  logic [BUSY_W-1:0]    busy_sh;
  logic                 cur_busy;
  logic                 take_fb;

  logic [SEG_ID_W-1:0]  in_seg;
  logic [BYTES_W-1:0]   in_amount;
  logic [BYTES_W-1:0]   in_req;
  logic [BUSY_W-1:0]    in_busy;

  logic [SEG_W-1:0]     cls_last;
  logic [LOC_W-1:0]     start_loc;
  logic [CNT_W-1:0]     loc_inc;
  logic [CNT_W-1:0]     scan_loc_inc;

  assign in_seg    = in_tdata[3:0];
  assign in_amount = in_tdata[35:4];
  assign in_req    = in_tdata[67:36];
  assign in_busy   = in_tdata[79:68];

  assign in_tready  = (state_r == S_IDLE) && !out_valid_r;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_aligned_r, out_cls_r, out_seg_r, out_found_r};

  scss_fit_unit u_fit (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (fc_wr),
    .rd_idx  (cur_idx),
    .need    (need_r),
    .rd_free (cur_free),
    .fits    (cur_fits)
  );

  assign cur_idx  = base_r + SEG_W'(loc_r);
  // Segments past the mask width shift out to zero: never busy.
  assign busy_sh  = busy_r >> cur_idx;
  assign cur_busy = busy_sh[0];
  assign take_fb  = cur_fits && (!have_fb_r || (fb_free_r < cur_free));

  // Next-fit start: one past the last used segment of the class, wrapped; location 1 if it lies outside the class.
  always_comb begin
    cls_last = last_used_r[cls_nxt];
    loc_inc  = '0;
    if ((int'(cls_last) >= int'(base_nxt)) &&
        (int'(cls_last) < int'(base_nxt) + int'(cnt_nxt))) begin
      loc_inc = CNT_W'(cls_last - base_nxt) + CNT_W'(1);
    end else begin
      loc_inc = CNT_W'(1);
    end
    start_loc = (loc_inc == cnt_nxt) ? '0 : LOC_W'(loc_inc);
  end

  assign scan_loc_inc = CNT_W'(loc_r) + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      have_fb_r   <= 1'b0;
      scan_cnt_r  <= '0;
      for (int i = 0; i < 3; i++) begin
        last_used_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      have_fb_r   <= have_fb_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      for (int i = 0; i < 3; i++) begin
        last_used_r[i] <= last_used_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r         <= req_nxt;
    busy_r        <= busy_nxt;
    aligned_r     <= aligned_nxt;
    need_r        <= need_nxt;
    cls_r         <= cls_nxt;
    base_r        <= base_nxt;
    cnt_r         <= cnt_nxt;
    loc_r         <= loc_nxt;
    fb_idx_r      <= fb_idx_nxt;
    fb_free_r     <= fb_free_nxt;
    out_found_r   <= out_found_nxt;
    out_seg_r     <= out_seg_nxt;
    out_cls_r     <= out_cls_nxt;
    out_aligned_r <= out_aligned_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      small_limit_r  <= BYTES_W'(256);
      medium_limit_r <= BYTES_W'(4096);
      header_r       <= HDR_W'(16);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SMALL_LIMIT:  small_limit_r  <= cfg_data;
        REG_MEDIUM_LIMIT: medium_limit_r <= cfg_data;
        REG_HEADER_BYTES: header_r       <= cfg_data[HDR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt       = state_r;
    req_nxt         = req_r;
    busy_nxt        = busy_r;
    aligned_nxt     = aligned_r;
    need_nxt        = need_r;
    cls_nxt         = cls_r;
    base_nxt        = base_r;
    cnt_nxt         = cnt_r;
    loc_nxt         = loc_r;
    scan_cnt_nxt    = scan_cnt_r;
    have_fb_nxt     = have_fb_r;
    fb_idx_nxt      = fb_idx_r;
    fb_free_nxt     = fb_free_r;
    for (int i = 0; i < 3; i++) begin
      last_used_nxt[i] = last_used_r[i];
    end
    out_valid_nxt   = out_valid_r && !out_tready;
    out_found_nxt   = out_found_r;
    out_seg_nxt     = out_seg_r;
    out_cls_nxt     = out_cls_r;
    out_aligned_nxt = out_aligned_r;
    fc_wr.en        = 1'b0;
    fc_wr.idx       = SEG_W'(in_seg);
    fc_wr.data      = in_amount;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          if (in_tuser == OP_LOAD) begin
            fc_wr.en        = int'(in_seg) < TOTAL_SEGS;
            out_valid_nxt   = 1'b1;
            out_found_nxt   = 1'b0;
            out_seg_nxt     = '0;
            out_cls_nxt     = CLS_SMALL;
            out_aligned_nxt = '0;
          end else begin
            req_nxt   = in_req;
            busy_nxt  = in_busy;
            state_nxt = S_ALIGN;
          end
        end
      end
      S_ALIGN: begin
        aligned_nxt = (ALIGNED_W'(req_r) + ALIGN_MASK) & ~ALIGN_MASK;
        state_nxt   = S_CLASS;
      end
      S_CLASS: begin
        if (aligned_r <= ALIGNED_W'(small_limit_r)) begin
          cls_nxt = CLS_SMALL;
        end else if (aligned_r <= ALIGNED_W'(medium_limit_r)) begin
          cls_nxt = CLS_MEDIUM;
        end else begin
          cls_nxt = CLS_LARGE;
        end
        base_nxt     = class_base(cls_nxt);
        cnt_nxt      = class_count(cls_nxt);
        loc_nxt      = start_loc;
        need_nxt     = NEED_W'(aligned_r) + NEED_W'(header_r);
        scan_cnt_nxt = '0;
        have_fb_nxt  = 1'b0;
        if (req_r == '0) begin
          out_valid_nxt   = 1'b1;
          out_found_nxt   = 1'b0;
          out_seg_nxt     = '0;
          out_cls_nxt     = cls_nxt;
          out_aligned_nxt = aligned_r;
          state_nxt       = S_IDLE;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (take_fb) begin
          fb_idx_nxt  = cur_idx;
          fb_free_nxt = cur_free;
        end
        have_fb_nxt = have_fb_r || cur_fits;
        if (cur_fits && !cur_busy) begin
          // first free fitting segment wins
          out_valid_nxt          = 1'b1;
          out_found_nxt          = 1'b1;
          out_seg_nxt            = SEG_ID_W'(cur_idx);
          out_cls_nxt            = cls_r;
          out_aligned_nxt        = aligned_r;
          last_used_nxt[cls_r]   = cur_idx;
          state_nxt              = S_IDLE;
        end else if (scan_cnt_r == cnt_r - CNT_W'(1)) begin
          // end of class: fall back to the roomiest busy segment that fits, if any
          out_valid_nxt   = 1'b1;
          out_found_nxt   = have_fb_nxt;
          out_seg_nxt     = have_fb_nxt ? SEG_ID_W'(fb_idx_nxt) : '0;
          out_cls_nxt     = cls_r;
          out_aligned_nxt = aligned_r;
          if (have_fb_nxt) begin
            last_used_nxt[cls_r] = fb_idx_nxt;
          end
          state_nxt = S_IDLE;
        end else begin
          loc_nxt      = (scan_loc_inc == cnt_r) ? '0 : LOC_W'(scan_loc_inc);
          scan_cnt_nxt = scan_cnt_r + CNT_W'(1);
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_none_zero_seg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_found_r |-> out_seg_r == '0)
    else $error("result without a segment carries a nonzero index");

  a_found_recorded: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_found_r
      |-> SEG_ID_W'(last_used_r[out_cls_r]) == out_seg_r)
    else $error("chosen segment not recorded as last used");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> scan_cnt_r < cnt_r)
    else $error("scan ran past the class segments");

  a_fallback_fits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN && have_fb_r |-> NEED_W'(fb_free_r) >= need_r)
    else $error("fallback segment does not fit the request");

  a_busy_while_work: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |=> !out_valid_r || state_r == S_IDLE)
    else $error("result shown while the scan is still running");

endmodule

`default_nettype wire

// ===== hdl/scss_fit_unit.sv =====
// ----------------------------------------------------------------------------
// scss_fit_unit: free count bank with the shared fit comparator
// Holds one free byte count per segment, takes one write per cycle and
// compares the count of the addressed segment against the needed size.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scss_fit_unit (
  input  wire                              clk,
  input  wire                              rst_n,
  input  scss_pkg::fc_wr_t                 wr,
  input  wire [scss_pkg::SEG_W-1:0]        rd_idx,
  input  wire [scss_pkg::NEED_W-1:0]       need,
  output logic [scss_pkg::BYTES_W-1:0]     rd_free,
  output logic                             fits
);
  import scss_pkg::*;

  logic [BYTES_W-1:0] free_r [TOTAL_SEGS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TOTAL_SEGS; i++) begin
        free_r[i] <= '0;
      end
    end else if (wr.en) begin
      free_r[wr.idx] <= wr.data;
    end
  end

  assign rd_free = free_r[rd_idx];
  assign fits    = NEED_W'(rd_free) >= need;

endmodule

`default_nettype wire
